### sv/plv_pkg.sv
// Shared types, constants and fixed-point helpers for the vertex lighting block.
`timescale 1ns / 1ps
package plv_pkg;

  // Specular exponent: number of chained Q1.15 multiplies.
  localparam int SHININESS  = 16;
  localparam int ONE_Q15    = 32768;
  localparam int FIFTH_Q15  = 6554;
  localparam int OUT_MAX    = 131071;

  // Pipeline depths.
  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 17;
  localparam int NORM_LAT   = SQRT_STEPS + DIV_STEPS + 3;
  localparam int SHADE_LAT  = SHININESS + 9;
  localparam int TOTAL_LAT  = NORM_LAT + SHADE_LAT + 1;

  localparam int CFG_W      = 48;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LIGHT_POS  = 3'd0,
    REG_CAMERA_POS = 3'd1,
    REG_AMBIENT    = 3'd2,
    REG_DIFFUSE    = 3'd3,
    REG_SPECULAR   = 3'd4,
    REG_MATERIAL   = 3'd5
  } cfg_idx_t;

  typedef logic signed [16:0] s17_t;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        base_red;
    logic [15:0]        base_green;
    logic [15:0]        base_blue;
  } in_req_t;

  typedef struct packed {
    logic [16:0] lit_red;
    logic [16:0] lit_green;
    logic [16:0] lit_blue;
  } out_res_t;

  // Product of two unsigned Q1.15 values, rounded half up.
  function automatic logic [16:0] mul_q15(input logic [16:0] a, input logic [16:0] b);
    logic [33:0] p;
    p = 34'(a) * 34'(b) + 34'd16384;
    return p[31:15];
  endfunction

  // Signed scale by 2^-15, rounded half up.
  function automatic logic signed [39:0] rnd_q15(input logic signed [39:0] x);
    logic signed [39:0] y;
    y = x + 40'sd16384;
    return y >>> 15;
  endfunction

  // Intensity lanes are limited to 1.0 on write.
  function automatic logic [15:0] clamp_one(input logic [15:0] x);
    return (x > 16'h8000) ? 16'h8000 : x;
  endfunction

endpackage

### sv/plv_norm.sv
// Pipelined normalizer: square sum, digit-serial square root, restoring divide.
`timescale 1ns / 1ps
module plv_norm (
  input  logic         clk,
  input  logic         en,
  input  plv_pkg::s17_t d_i [3],
  output plv_pkg::s17_t u_o [3]
);

  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][15:0] mag;
  } nside_t;

  localparam int SQ = plv_pkg::SQRT_STEPS;
  localparam int DV = plv_pkg::DIV_STEPS;

  logic [2:0][15:0] a1_r;
  logic [2:0]       neg1_r;
  logic [31:0]      sq1_r [3];
  logic [33:0]      s2_r;
  nside_t           side2_r;

  logic [61:0]      x_r    [SQ];
  logic [61:0]      root_r [SQ];
  nside_t           sside_r[SQ];

  logic [45:0]      rem_r  [DV][3];
  logic [16:0]      q_r    [DV][3];
  logic [30:0]      dmag_r [DV];
  nside_t           dside_r[DV];

  plv_pkg::s17_t    u_r [3];

  // Magnitudes and squares of each lane.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [16:0] nd;
        logic [15:0]        a;
        nd = -d_i[k];
        a  = d_i[k][16] ? nd[15:0] : d_i[k][15:0];
        a1_r[k]   <= a;
        neg1_r[k] <= d_i[k][16];
        sq1_r[k]  <= 32'(a) * 32'(a);
      end
    end
  end

  // Squared length and zero-vector flag.
  always_ff @(posedge clk) begin
    if (en) begin
      s2_r         <= 34'(sq1_r[0]) + 34'(sq1_r[1]) + 34'(sq1_r[2]);
      side2_r.mag  <= a1_r;
      side2_r.neg  <= neg1_r;
      side2_r.zero <= (sq1_r[0] == 32'd0) && (sq1_r[1] == 32'd0) && (sq1_r[2] == 32'd0);
    end
  end

  // Square root of the squared length scaled by 2^28, one result bit per stage.
  for (genvar j = 0; j < SQ; j++) begin : g_sqrt
    localparam logic [61:0] BIT = 62'(1) << (2 * (SQ - 1 - j));
    logic [61:0] x_in, r_in, t, x_nx, r_nx;
    nside_t      s_in;
    if (j == 0) begin : g_first
      assign x_in = {s2_r[33:0], 28'd0};
      assign r_in = '0;
      assign s_in = side2_r;
    end else begin : g_next
      assign x_in = x_r[j-1];
      assign r_in = root_r[j-1];
      assign s_in = sside_r[j-1];
    end
    always_comb begin
      t = r_in + BIT;
      if (x_in >= t) begin
        x_nx = x_in - t;
        r_nx = (r_in >> 1) + BIT;
      end else begin
        x_nx = x_in;
        r_nx = r_in >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[j]     <= x_nx;
        root_r[j]  <= r_nx;
        sside_r[j] <= s_in;
      end
    end
  end

  // Rounded quotient per lane, one quotient bit per stage.
  for (genvar i = 0; i < DV; i++) begin : g_div
    logic [45:0] rem_in [3];
    logic [16:0] q_in   [3];
    logic [30:0] m_in;
    nside_t      s_in;
    logic [45:0] rem_nx [3];
    logic [16:0] q_nx   [3];
    if (i == 0) begin : g_first
      assign m_in = root_r[SQ-1][30:0];
      assign s_in = sside_r[SQ-1];
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign rem_in[k] = 46'({s_in.mag[k], 29'd0}) + 46'(m_in[30:1]);
        assign q_in[k]   = '0;
      end
    end else begin : g_next
      assign m_in = dmag_r[i-1];
      assign s_in = dside_r[i-1];
      for (genvar k = 0; k < 3; k++) begin : g_lane
        assign rem_in[k] = rem_r[i-1][k];
        assign q_in[k]   = q_r[i-1][k];
      end
    end
    always_comb begin
      logic [47:0] dv;
      dv = 48'(m_in) << (DV - 1 - i);
      for (int k = 0; k < 3; k++) begin
        rem_nx[k] = rem_in[k];
        q_nx[k]   = q_in[k];
        if (48'(rem_in[k]) >= dv) begin
          rem_nx[k]         = 46'(48'(rem_in[k]) - dv);
          q_nx[k][DV-1-i]   = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        for (int k = 0; k < 3; k++) begin
          rem_r[i][k] <= rem_nx[k];
          q_r[i][k]   <= q_nx[k];
        end
        dmag_r[i]  <= m_in;
        dside_r[i] <= s_in;
      end
    end
  end

  // Limit to 1.0, restore the sign, force zero for a zero vector.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic [16:0] qc;
        qc = (q_r[DV-1][k] > 17'd32768) ? 17'd32768 : q_r[DV-1][k];
        if (dside_r[DV-1].zero) begin
          u_r[k] <= '0;
        end else if (dside_r[DV-1].neg[k]) begin
          u_r[k] <= 17'd0 - qc;
        end else begin
          u_r[k] <= qc;
        end
      end
    end
  end

  assign u_o = u_r;

endmodule

### sv/plv_shade.sv
// Lighting pipeline: dot products, reflection, specular power and color sum.
`timescale 1ns / 1ps
module plv_shade (
  input  logic              clk,
  input  logic              en,
  input  plv_pkg::s17_t     n_i [3],
  input  plv_pkg::s17_t     l_i [3],
  input  plv_pkg::s17_t     v_i [3],
  input  logic [2:0][15:0]  base_i,
  input  logic [15:0]       amb_i [3],
  input  logic [15:0]       dif_i [3],
  input  logic [15:0]       spe_i [3],
  input  logic [15:0]       mat_i [3],
  output plv_pkg::out_res_t lit_o
);

  localparam int SH = plv_pkg::SHININESS;

  plv_pkg::s17_t      n_a [3], l_a [3], v_a [3];
  logic signed [33:0] nlp_a [3];
  logic [2:0][15:0]   base_a;

  plv_pkg::s17_t      n_b [3], l_b [3], v_b [3];
  plv_pkg::s17_t      nl_b;
  logic [2:0][15:0]   base_b;

  plv_pkg::s17_t      l_c [3], v_c [3];
  logic signed [33:0] nnp_c [3];
  plv_pkg::s17_t      nl_c;
  logic [2:0][15:0]   base_c;

  plv_pkg::s17_t      v_d [3];
  logic signed [17:0] r_d [3];
  plv_pkg::s17_t      nl_d;
  logic [2:0][15:0]   base_d;

  logic signed [34:0] vrp_e [3];
  plv_pkg::s17_t      nl_e;
  logic [2:0][15:0]   base_e;

  logic [15:0]        kk_f;
  plv_pkg::s17_t      nl_f;
  logic [2:0][15:0]   base_f;

  logic [15:0]        pw_r   [SH];
  logic [15:0]        kk_p   [SH];
  plv_pkg::s17_t      nl_p   [SH];
  logic [2:0][15:0]   base_p [SH];

  logic [16:0]        fb_g [3], si_g [3];
  logic [16:0]        dif_h [3], spe_h [3], amb_h [3];
  plv_pkg::out_res_t  lit_r;

  // N.L lane products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        nlp_a[k] <= 34'(n_i[k]) * 34'(l_i[k]);
        n_a[k]   <= n_i[k];
        l_a[k]   <= l_i[k];
        v_a[k]   <= v_i[k];
      end
      base_a <= base_i;
    end
  end

  // N.L sum, rounded and limited to plus or minus 1.0.
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [39:0] t;
      t = plv_pkg::rnd_q15(40'(36'(nlp_a[0]) + 36'(nlp_a[1]) + 36'(nlp_a[2])));
      if (t > 40'sd32768) begin
        nl_b <= 17'sd32768;
      end else if (t < -40'sd32768) begin
        nl_b <= -17'sd32768;
      end else begin
        nl_b <= t[16:0];
      end
      n_b    <= n_a;
      l_b    <= l_a;
      v_b    <= v_a;
      base_b <= base_a;
    end
  end

  // (N.L) times each lane of N.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        nnp_c[k] <= 34'(nl_b) * 34'(n_b[k]);
      end
      l_c    <= l_b;
      v_c    <= v_b;
      nl_c   <= nl_b;
      base_c <= base_b;
    end
  end

  // Reflection vector R = 2(N.L)N - L.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [39:0] t;
        t = plv_pkg::rnd_q15(40'(nnp_c[k]) <<< 1) - 40'(l_c[k]);
        r_d[k] <= t[17:0];
      end
      v_d    <= v_c;
      nl_d   <= nl_c;
      base_d <= base_c;
    end
  end

  // V.R lane products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        vrp_e[k] <= 35'(v_d[k]) * 35'(r_d[k]);
      end
      nl_e   <= nl_d;
      base_e <= base_d;
    end
  end

  // V.R sum, limited to [0, 1.0].
  always_ff @(posedge clk) begin
    if (en) begin
      logic signed [39:0] t;
      t = plv_pkg::rnd_q15(40'(37'(vrp_e[0]) + 37'(vrp_e[1]) + 37'(vrp_e[2])));
      if (t < 40'sd0) begin
        kk_f <= '0;
      end else if (t > 40'sd32768) begin
        kk_f <= 16'h8000;
      end else begin
        kk_f <= t[15:0];
      end
      nl_f   <= nl_e;
      base_f <= base_e;
    end
  end

  // Specular power: one rounded multiply per stage.
  for (genvar p = 0; p < SH; p++) begin : g_pow
    logic [15:0]      pw_in, kk_in;
    plv_pkg::s17_t    nl_in;
    logic [2:0][15:0] base_in;
    logic [16:0]      prod;
    if (p == 0) begin : g_first
      assign pw_in   = 16'(plv_pkg::ONE_Q15);
      assign kk_in   = kk_f;
      assign nl_in   = nl_f;
      assign base_in = base_f;
    end else begin : g_next
      assign pw_in   = pw_r[p-1];
      assign kk_in   = kk_p[p-1];
      assign nl_in   = nl_p[p-1];
      assign base_in = base_p[p-1];
    end
    assign prod = plv_pkg::mul_q15(17'(pw_in), 17'(kk_in));
    always_ff @(posedge clk) begin
      if (en) begin
        pw_r[p]   <= prod[15:0];
        kk_p[p]   <= kk_in;
        nl_p[p]   <= nl_in;
        base_p[p] <= base_in;
      end
    end
  end

  // Diffuse factor times base color; specular intensity times power.
  always_ff @(posedge clk) begin
    if (en) begin
      logic [15:0] f;
      f = (nl_p[SH-1] < 17'sd6554) ? 16'(plv_pkg::FIFTH_Q15) : nl_p[SH-1][15:0];
      for (int k = 0; k < 3; k++) begin
        fb_g[k] <= plv_pkg::mul_q15(17'(f), 17'(base_p[SH-1][k]));
        si_g[k] <= plv_pkg::mul_q15(17'(spe_i[k]), 17'(pw_r[SH-1]));
      end
    end
  end

  // Ambient, diffuse and specular terms.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        amb_h[k] <= plv_pkg::mul_q15(17'(amb_i[k]), 17'(plv_pkg::FIFTH_Q15));
        dif_h[k] <= plv_pkg::mul_q15(17'(dif_i[k]), fb_g[k]);
        spe_h[k] <= plv_pkg::mul_q15(si_g[k], 17'(mat_i[k]));
      end
    end
  end

  // Channel sums with saturation; this is the output register.
  always_ff @(posedge clk) begin
    if (en) begin
      logic [17:0] s [3];
      logic [16:0] c [3];
      for (int k = 0; k < 3; k++) begin
        s[k] = 18'(amb_h[k]) + 18'(dif_h[k]) + 18'(spe_h[k]);
        c[k] = (s[k] > 18'(plv_pkg::OUT_MAX)) ? 17'(plv_pkg::OUT_MAX) : s[k][16:0];
      end
      lit_r.lit_red   <= c[0];
      lit_r.lit_green <= c[1];
      lit_r.lit_blue  <= c[2];
    end
  end

  assign lit_o = lit_r;

endmodule

### sv/phong_vertex_lighting_top.sv
// Top level of the point-light vertex lighting pipeline.
`timescale 1ns / 1ps
// Usage:
//   A request on in_req (point, unnormalized normal, base color) is taken at a
//   clock edge with in_valid high and in_stall low. One lit color per request
//   leaves on out_res, taken when out_valid is high and out_stall is low.
//   The configuration port writes one of six 48-bit registers per cycle with
//   cfg_wr_en; it should only be written while no request is in flight.
//   Intensity writes are limited to 1.0 per lane; unknown indexes are ignored.
// Timing:
//   The pipeline is 77 register stages deep: 51 in the normalizers (a square
//   root with one result bit per stage and a divider with one quotient bit per
//   stage), 25 in the lighting math (including one stage per multiply of the
//   16-step specular power) and one input stage. Unless a held result stalls
//   the pipeline, a new request can be taken and one result leaves every cycle.
// Reset and stalls:
//   Synchronous reset empties the pipeline and loads the default registers.
//   While a finished result waits under out_stall, the whole pipeline holds
//   and in_stall is raised; nothing is dropped or repeated.
module phong_vertex_lighting_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  plv_pkg::in_req_t              in_req,
  output logic                          out_valid,
  input  logic                          out_stall,
  output plv_pkg::out_res_t             out_res,
  input  logic                          cfg_wr_en,
  input  logic [2:0]                    cfg_index,
  input  logic [plv_pkg::CFG_W-1:0]     cfg_data
);

  localparam int TL = plv_pkg::TOTAL_LAT;
  localparam int NL = plv_pkg::NORM_LAT;

  logic [15:0] light_r [3], cam_r [3];
  logic [15:0] amb_r [3], dif_r [3], spe_r [3], mat_r [3];

  logic [TL-1:0]    vld_r;
  logic             en;

  plv_pkg::s17_t    nd_r [3], ld_r [3], vd_r [3];
  logic [2:0][15:0] base_r [NL+1];
  logic signed [15:0] pnt [3];
  logic signed [15:0] nrm [3];

  plv_pkg::s17_t    n_u [3], l_u [3], v_u [3];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        light_r[k] <= '0;
        cam_r[k]   <= '0;
        amb_r[k]   <= 16'h2666;
        dif_r[k]   <= 16'h8000;
        spe_r[k]   <= 16'h8000;
        mat_r[k]   <= '0;
      end
    end else if (cfg_wr_en) begin
      for (int k = 0; k < 3; k++) begin
        case (cfg_index)
          plv_pkg::REG_LIGHT_POS:  light_r[k] <= cfg_data[16*k +: 16];
          plv_pkg::REG_CAMERA_POS: cam_r[k]   <= cfg_data[16*k +: 16];
          plv_pkg::REG_AMBIENT:    amb_r[k]   <= plv_pkg::clamp_one(cfg_data[16*k +: 16]);
          plv_pkg::REG_DIFFUSE:    dif_r[k]   <= plv_pkg::clamp_one(cfg_data[16*k +: 16]);
          plv_pkg::REG_SPECULAR:   spe_r[k]   <= plv_pkg::clamp_one(cfg_data[16*k +: 16]);
          plv_pkg::REG_MATERIAL:   mat_r[k]   <= cfg_data[16*k +: 16];
          default: ;
        endcase
      end
    end
  end

  // The whole pipeline moves unless a finished result is held at the output.
  assign en       = !(vld_r[TL-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TL-2:0], in_valid};
    end
  end

  assign pnt = '{in_req.point_x, in_req.point_y, in_req.point_z};
  assign nrm = '{in_req.normal_x, in_req.normal_y, in_req.normal_z};

  // Input stage: difference vectors to the light and the camera.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        nd_r[k] <= {nrm[k][15], nrm[k]};
        ld_r[k] <= {light_r[k][15], light_r[k]} - {pnt[k][15], pnt[k]};
        vd_r[k] <= {cam_r[k][15], cam_r[k]} - {pnt[k][15], pnt[k]};
      end
      base_r[0] <= {in_req.base_blue, in_req.base_green, in_req.base_red};
    end
  end

  // Base color rides alongside the normalizers.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 1; s <= NL; s++) begin
        base_r[s] <= base_r[s-1];
      end
    end
  end

  plv_norm u_norm_n (.clk(clk), .en(en), .d_i(nd_r), .u_o(n_u));
  plv_norm u_norm_l (.clk(clk), .en(en), .d_i(ld_r), .u_o(l_u));
  plv_norm u_norm_v (.clk(clk), .en(en), .d_i(vd_r), .u_o(v_u));

  plv_shade u_shade (
    .clk    (clk),
    .en     (en),
    .n_i    (n_u),
    .l_i    (l_u),
    .v_i    (v_u),
    .base_i (base_r[NL]),
    .amb_i  (amb_r),
    .dif_i  (dif_r),
    .spe_i  (spe_r),
    .mat_i  (mat_r),
    .lit_o  (out_res)
  );

  assign out_valid = vld_r[TL-1];

  // A held result must block the input side.
  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[TL-1] && out_stall) |-> in_stall)
    else $error("result held but input not stalled");

  // An accepted request enters the first stage.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted request lost at input stage");

  // A stalled pipeline keeps every valid bit.
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Stored intensities never exceed 1.0 (checked on one lane of each register).
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (amb_r[0] <= 16'h8000) && (dif_r[1] <= 16'h8000) && (spe_r[2] <= 16'h8000))
    else $error("intensity register above 1.0");

endmodule
